@@ hdl/assert_macros.svh @@
// Assertion macros shared by the running mean / deviation RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RMSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define RMSD_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hdl/rmsd_pkg.sv @@
// Widths, status types and shared constants for the running mean / deviation block.
package rmsd_pkg;

    // Field and accumulator widths
    localparam int FIELD_BITS    = 16;
    localparam int SAMPLE_BITS   = 16;
    localparam int COUNT_BITS    = 16;
    localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS - 2 + COUNT_BITS;
    localparam int MAG_BITS      = SAMPLE_BITS;

    // Serial multiplier: multiplicand, multiplier and product widths
    localparam int MC_BITS       = SQ_BITS;
    localparam int MP_BITS       = SUM_BITS;
    localparam int PROD_BITS     = 2 * SUM_BITS;

    // Serial divider (remainder, dividend low word, divisor, quotient)
    localparam int DIV_BITS      = SUM_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);

    // Digit-by-digit square root
    localparam int ROOT_BITS     = SAMPLE_BITS;
    localparam int RAD_BITS      = 2 * ROOT_BITS;
    localparam int ROOT_REM_BITS = ROOT_BITS + 2;
    localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

@@ hdl/rmsd_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle, early finish on zero.
module rmsd_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rmsd_pkg::MC_BITS-1:0]   i_mcand,
    input  logic [rmsd_pkg::MP_BITS-1:0]   i_mplier,
    output logic [rmsd_pkg::PROD_BITS-1:0] o_prod,
    output rmsd_pkg::t_unit_stat           o_stat
);

    logic                           r_busy, n_busy;
    logic [rmsd_pkg::PROD_BITS-1:0] r_acc, n_acc;
    logic [rmsd_pkg::PROD_BITS-1:0] r_mc, n_mc;
    logic [rmsd_pkg::MP_BITS-1:0]   r_mp, n_mp;
    logic                           mp_empty;

    assign mp_empty = (r_mp == '0);

    // One partial product per cycle; multiplicand shifts up, multiplier shifts down
    always_comb begin
        n_busy = r_busy;
        n_acc  = r_acc;
        n_mc   = r_mc;
        n_mp   = r_mp;
        if (i_start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_mc   = {{(rmsd_pkg::PROD_BITS - rmsd_pkg::MC_BITS){1'b0}}, i_mcand};
            n_mp   = i_mplier;
        end else if (r_busy) begin
            if (mp_empty) begin
                n_busy = 1'b0;
            end else begin
                if (r_mp[0]) begin
                    n_acc = r_acc + r_mc;
                end
                n_mc = {r_mc[rmsd_pkg::PROD_BITS-2:0], 1'b0};
                n_mp = {1'b0, r_mp[rmsd_pkg::MP_BITS-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_acc <= n_acc;
        r_mc  <= n_mc;
        r_mp  <= n_mp;
    end

    assign o_prod      = r_acc;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && mp_empty;

endmodule

@@ hdl/rmsd_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
module rmsd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rmsd_pkg::DIV_BITS-1:0] i_rem,
    input  logic [rmsd_pkg::DIV_BITS-1:0] i_low,
    input  logic [rmsd_pkg::DIV_BITS-1:0] i_divisor,
    output logic [rmsd_pkg::DIV_BITS-1:0] o_quot,
    output rmsd_pkg::t_unit_stat          o_stat
);

    logic                              r_busy, n_busy;
    logic [rmsd_pkg::DIV_CNT_BITS-1:0] r_cnt, n_cnt;
    logic [rmsd_pkg::DIV_BITS-1:0]     r_rem, n_rem;
    logic [rmsd_pkg::DIV_BITS-1:0]     r_low, n_low;
    logic [rmsd_pkg::DIV_BITS-1:0]     r_dvs, n_dvs;
    logic [rmsd_pkg::DIV_BITS:0]       trial;
    logic [rmsd_pkg::DIV_BITS:0]       dvs_ext;
    logic [rmsd_pkg::DIV_BITS:0]       diff;
    logic                              q_bit;

    // Shift in the next dividend bit and try the subtract
    assign trial   = {r_rem, r_low[rmsd_pkg::DIV_BITS-1]};
    assign dvs_ext = {1'b0, r_dvs};
    assign diff    = trial - dvs_ext;
    assign q_bit   = (trial >= dvs_ext);

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = rmsd_pkg::DIV_CNT_BITS'(rmsd_pkg::DIV_BITS);
            n_rem  = i_rem;
            n_low  = i_low;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
                n_rem = q_bit ? diff[rmsd_pkg::DIV_BITS-1:0]
                              : trial[rmsd_pkg::DIV_BITS-1:0];
                n_low = {r_low[rmsd_pkg::DIV_BITS-2:0], q_bit};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_low <= n_low;
        r_dvs <= n_dvs;
    end

    // Quotient bits collect in the low word as the dividend shifts out
    assign o_quot      = r_low;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_busy && (r_cnt == '0);

endmodule

@@ hdl/running_mean_std_deviation_top.sv @@
// Running mean and population standard deviation of a signed sample stream.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   input   | in        | i_valid / o_stall    | i_sample, i_last
//   output  | out       | o_valid / i_stall    | o_mean_value, o_std_dev, o_sample_total,
//           |           |                      | o_saturated
//
// One request at a time; the time from acceptance to the next free slot is set by the serial
// multiplier (square, n*sumsq, sum*sum, n*n, one bit per cycle, stops early on small operands),
// the 32-step mean divide that the 32-step variance divide waits behind, and the 16-step root;
// the square is skipped when the count is full.
// Reset is synchronous, active low, and clears the count, sum and sum of squares.
// A new request is taken while a finished result waits in the output register;
// its result waits at the end of the sequence until the output side takes the old one.
module running_mean_std_deviation_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [rmsd_pkg::FIELD_BITS-1:0] i_sample,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rmsd_pkg::FIELD_BITS-1:0] o_mean_value,
    output logic [rmsd_pkg::FIELD_BITS-1:0] o_std_dev,
    output logic [rmsd_pkg::FIELD_BITS-1:0] o_sample_total,
    output logic                            o_saturated
);

`include "assert_macros.svh"

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_SQUARE   = 10'b00_0000_0010,
        ST_LAUNCH   = 10'b00_0000_0100,
        ST_MUL_A    = 10'b00_0000_1000,
        ST_MUL_B    = 10'b00_0001_0000,
        ST_MUL_N    = 10'b00_0010_0000,
        ST_DIV_WAIT = 10'b00_0100_0000,
        ST_DIV_V    = 10'b00_1000_0000,
        ST_ROOT     = 10'b01_0000_0000,
        ST_WB       = 10'b10_0000_0000
    } t_state;

    t_state                                r_state, n_state;

    // Request and accumulators
    logic [rmsd_pkg::SAMPLE_BITS-1:0]      r_smp, n_smp;
    logic                                  r_last, n_last;
    logic                                  r_sat, n_sat;
    logic [rmsd_pkg::COUNT_BITS-1:0]       r_count, n_count;
    logic [rmsd_pkg::SUM_BITS-1:0]         r_sum, n_sum;
    logic [rmsd_pkg::SQ_BITS-1:0]          r_sumsq, n_sumsq;

    // Intermediate results
    logic [rmsd_pkg::PROD_BITS-1:0]        r_a, n_a;
    logic [rmsd_pkg::PROD_BITS-1:0]        r_d, n_d;
    logic [rmsd_pkg::DIV_BITS-1:0]         r_nn, n_nn;
    logic [rmsd_pkg::FIELD_BITS-1:0]       r_mean, n_mean;

    // Square root
    logic [rmsd_pkg::RAD_BITS-1:0]         r_rad, n_rad;
    logic [rmsd_pkg::ROOT_REM_BITS-1:0]    r_rrem, n_rrem;
    logic [rmsd_pkg::ROOT_BITS-1:0]        r_root, n_root;
    logic [rmsd_pkg::ROOT_CNT_BITS-1:0]    r_rcnt, n_rcnt;

    // Output register
    logic                                  r_out_valid, n_out_valid;
    logic [rmsd_pkg::FIELD_BITS-1:0]       r_o_mean, n_o_mean;
    logic [rmsd_pkg::FIELD_BITS-1:0]       r_o_std, n_o_std;
    logic [rmsd_pkg::FIELD_BITS-1:0]       r_o_total, n_o_total;
    logic                                  r_o_sat, n_o_sat;

    // Arithmetic unit hookup
    logic                                  mul_start;
    logic [rmsd_pkg::MC_BITS-1:0]          mul_mcand;
    logic [rmsd_pkg::MP_BITS-1:0]          mul_mplier;
    logic [rmsd_pkg::PROD_BITS-1:0]        mul_prod;
    rmsd_pkg::t_unit_stat                  mul_stat;
    logic                                  div_start;
    logic [rmsd_pkg::DIV_BITS-1:0]         div_rem;
    logic [rmsd_pkg::DIV_BITS-1:0]         div_low;
    logic [rmsd_pkg::DIV_BITS-1:0]         div_dvs;
    logic [rmsd_pkg::DIV_BITS-1:0]         div_quot;
    rmsd_pkg::t_unit_stat                  div_stat;

    // Misc combinational
    logic                                  accept;
    logic                                  sat_now;
    logic                                  out_load;
    logic [rmsd_pkg::SAMPLE_BITS-1:0]      smp_in;
    logic [rmsd_pkg::MAG_BITS-1:0]         mag_in;
    logic [rmsd_pkg::SUM_BITS-1:0]         asum;
    logic [rmsd_pkg::SUM_BITS-1:0]         smp_ext;
    logic [rmsd_pkg::DIV_BITS-1:0]         quot_neg;
    logic [rmsd_pkg::ROOT_REM_BITS+1:0]    root_sh;
    logic [rmsd_pkg::ROOT_REM_BITS+1:0]    root_trial;
    logic [rmsd_pkg::ROOT_REM_BITS+1:0]    root_diff;
    logic                                  root_bit;

    // Handshake
    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_WB) && (!r_out_valid || !i_stall);

    // Sample magnitude, sign extension and sum magnitude
    assign smp_in  = i_sample[rmsd_pkg::SAMPLE_BITS-1:0];
    assign mag_in  = smp_in[rmsd_pkg::SAMPLE_BITS-1] ? (~smp_in + 1'b1) : smp_in;
    assign smp_ext = {{(rmsd_pkg::SUM_BITS - rmsd_pkg::SAMPLE_BITS)
                       {r_smp[rmsd_pkg::SAMPLE_BITS-1]}}, r_smp};
    assign asum    = r_sum[rmsd_pkg::SUM_BITS-1] ? (~r_sum + 1'b1) : r_sum;
    assign sat_now = (r_count == '1);
    assign quot_neg = ~div_quot + 1'b1;

    // Root step: bring down two radicand bits, try subtracting 4*root+1
    assign root_sh    = {r_rrem, r_rad[rmsd_pkg::RAD_BITS-1 -: 2]};
    assign root_trial = {2'b00, r_root, 2'b01};
    assign root_diff  = root_sh - root_trial;
    assign root_bit   = (root_sh >= root_trial);

    // Unit start requests and operands
    always_comb begin
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = '0;
        div_start  = 1'b0;
        div_rem    = '0;
        div_low    = '0;
        div_dvs    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !sat_now) begin
                    mul_start  = 1'b1;
                    mul_mcand  = rmsd_pkg::MC_BITS'(mag_in);
                    mul_mplier = rmsd_pkg::MP_BITS'(mag_in);
                end
            end
            ST_LAUNCH: begin
                mul_start  = 1'b1;
                mul_mcand  = r_sumsq;
                mul_mplier = rmsd_pkg::MP_BITS'(r_count);
                div_start  = 1'b1;
                div_low    = asum;
                div_dvs    = rmsd_pkg::DIV_BITS'(r_count);
            end
            ST_MUL_A: begin
                if (mul_stat.done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = rmsd_pkg::MC_BITS'(asum);
                    mul_mplier = asum;
                end
            end
            ST_MUL_B: begin
                if (mul_stat.done) begin
                    mul_start  = 1'b1;
                    mul_mcand  = rmsd_pkg::MC_BITS'(r_count);
                    mul_mplier = rmsd_pkg::MP_BITS'(r_count);
                end
            end
            ST_DIV_WAIT: begin
                if (!div_stat.busy) begin
                    div_start = 1'b1;
                    div_rem   = r_d[rmsd_pkg::PROD_BITS-1 -: rmsd_pkg::DIV_BITS];
                    div_low   = r_d[rmsd_pkg::DIV_BITS-1:0];
                    div_dvs   = r_nn;
                end
            end
            ST_SQUARE, ST_MUL_N, ST_DIV_V, ST_ROOT, ST_WB: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_smp       = r_smp;
        n_last      = r_last;
        n_sat       = r_sat;
        n_count     = r_count;
        n_sum       = r_sum;
        n_sumsq     = r_sumsq;
        n_a         = r_a;
        n_d         = r_d;
        n_nn        = r_nn;
        n_mean      = r_mean;
        n_rad       = r_rad;
        n_rrem      = r_rrem;
        n_root      = r_root;
        n_rcnt      = r_rcnt;
        n_out_valid = r_out_valid && i_stall;
        n_o_mean    = r_o_mean;
        n_o_std     = r_o_std;
        n_o_total   = r_o_total;
        n_o_sat     = r_o_sat;

        // Mean quotient lands whenever the divider finishes the mean division
        if (div_stat.done && (r_state != ST_DIV_V)) begin
            n_mean = r_sum[rmsd_pkg::SUM_BITS-1] ? quot_neg[rmsd_pkg::FIELD_BITS-1:0]
                                                 : div_quot[rmsd_pkg::FIELD_BITS-1:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_smp   = smp_in;
                    n_last  = i_last;
                    n_sat   = sat_now;
                    n_state = sat_now ? ST_LAUNCH : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (mul_stat.done) begin
                    n_count = r_count + 1'b1;
                    n_sum   = r_sum + smp_ext;
                    n_sumsq = r_sumsq + mul_prod[rmsd_pkg::SQ_BITS-1:0];
                    n_state = ST_LAUNCH;
                end
            end
            ST_LAUNCH: begin
                n_state = ST_MUL_A;
            end
            ST_MUL_A: begin
                if (mul_stat.done) begin
                    n_a     = mul_prod;
                    n_state = ST_MUL_B;
                end
            end
            ST_MUL_B: begin
                if (mul_stat.done) begin
                    n_d     = (r_a > mul_prod) ? (r_a - mul_prod) : '0;
                    n_state = ST_MUL_N;
                end
            end
            ST_MUL_N: begin
                if (mul_stat.done) begin
                    n_nn    = mul_prod[rmsd_pkg::DIV_BITS-1:0];
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (!div_stat.busy) begin
                    n_state = ST_DIV_V;
                end
            end
            ST_DIV_V: begin
                if (div_stat.done) begin
                    n_rad   = div_quot[rmsd_pkg::RAD_BITS-1:0];
                    n_rrem  = '0;
                    n_root  = '0;
                    n_rcnt  = rmsd_pkg::ROOT_CNT_BITS'(rmsd_pkg::ROOT_BITS);
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                n_rrem = root_bit ? root_diff[rmsd_pkg::ROOT_REM_BITS-1:0]
                                  : root_sh[rmsd_pkg::ROOT_REM_BITS-1:0];
                n_root = {r_root[rmsd_pkg::ROOT_BITS-2:0], root_bit};
                n_rad  = {r_rad[rmsd_pkg::RAD_BITS-3:0], 2'b00};
                n_rcnt = r_rcnt - 1'b1;
                if (r_rcnt == rmsd_pkg::ROOT_CNT_BITS'(1)) begin
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                    n_o_mean    = r_mean;
                    n_o_std     = rmsd_pkg::FIELD_BITS'(r_root);
                    n_o_total   = rmsd_pkg::FIELD_BITS'(r_count);
                    n_o_sat     = r_sat;
                    if (r_last) begin
                        n_count = '0;
                        n_sum   = '0;
                        n_sumsq = '0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_rcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_sumsq     <= n_sumsq;
            r_rcnt      <= n_rcnt;
            r_out_valid <= n_out_valid;
        end
        r_smp     <= n_smp;
        r_last    <= n_last;
        r_sat     <= n_sat;
        r_a       <= n_a;
        r_d       <= n_d;
        r_nn      <= n_nn;
        r_mean    <= n_mean;
        r_rad     <= n_rad;
        r_rrem    <= n_rrem;
        r_root    <= n_root;
        r_o_mean  <= n_o_mean;
        r_o_std   <= n_o_std;
        r_o_total <= n_o_total;
        r_o_sat   <= n_o_sat;
    end

    // Shared serial multiplier: square, n*sumsq, sum*sum, n*n
    rmsd_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_mcand),
        .i_mplier (mul_mplier),
        .o_prod   (mul_prod),
        .o_stat   (mul_stat)
    );

    // Shared serial divider: mean, then variance
    rmsd_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_rem     (div_rem),
        .i_low     (div_low),
        .i_divisor (div_dvs),
        .o_quot    (div_quot),
        .o_stat    (div_stat)
    );

    assign o_valid        = r_out_valid;
    assign o_mean_value   = r_o_mean;
    assign o_std_dev      = r_o_std;
    assign o_sample_total = r_o_total;
    assign o_saturated    = r_o_sat;

    // Units are only restarted once idle or finishing
    `RMSD_ASSERT(a_mul_free, mul_start |-> (!mul_stat.busy || mul_stat.done), "mul restarted busy")
    `RMSD_ASSERT(a_div_free, div_start |-> (!div_stat.busy || div_stat.done), "div restarted busy")
    // Variance divisor is never zero
    `RMSD_ASSERT(a_nn_nonzero, (r_state == ST_DIV_V) |-> (r_count != '0 && r_nn != '0), "zero n")
    // Both units are quiet when the result is written out
    `RMSD_ASSERT_NEVER(a_wb_quiet, (r_state == ST_WB) && (mul_stat.busy || div_stat.busy), "unit busy at writeback")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the running mean / standard deviation block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected output request
    typedef struct packed {
        logic signed [rmsd_pkg::FIELD_BITS-1:0] mean_value;
        logic [rmsd_pkg::FIELD_BITS-1:0]        std_dev;
        logic [rmsd_pkg::FIELD_BITS-1:0]        sample_total;
        logic                                   saturated;
    } t_stats_result;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [rmsd_pkg::FIELD_BITS-1:0] i_sample;
    logic                            i_last;
    logic                            o_valid;
    logic                            i_stall;
    logic [rmsd_pkg::FIELD_BITS-1:0] o_mean_value;
    logic [rmsd_pkg::FIELD_BITS-1:0] o_std_dev;
    logic [rmsd_pkg::FIELD_BITS-1:0] o_sample_total;
    logic                            o_saturated;

    // Shadow accumulators of the current run
    logic [rmsd_pkg::COUNT_BITS-1:0] acc_count;
    longint                          acc_sum;
    logic [63:0]                     acc_sum_sq;

    t_stats_result pending_stats[$];
    int            stats_errors;
    int            burst_left;

    running_mean_std_deviation_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_mean_value   (o_mean_value),
        .o_std_dev      (o_std_dev),
        .o_sample_total (o_sample_total),
        .o_saturated    (o_saturated)
    );

    // 125 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #12_000_000;
        $display("FAIL running_mean_std_deviation_top");
        $finish;
    end

    // Floor square root, bit by bit from the top
    function automatic logic [63:0] floor_sqrt64(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    // Accumulate one sample and work out mean and population deviation
    function automatic t_stats_result predict_stats(
        input logic [rmsd_pkg::FIELD_BITS-1:0] smp,
        input logic lst);
        t_stats_result res;
        longint        sval;
        logic [63:0]   mag;
        logic [63:0]   n;
        logic [63:0]   asum;
        logic [63:0]   n_sq_sum;
        logic [63:0]   sum_sq;
        logic [63:0]   diff;
        logic [63:0]   var_val;
        longint        mean_full;
        sval = longint'($signed(smp));
        res  = '0;
        res.saturated = (acc_count == {rmsd_pkg::COUNT_BITS{1'b1}});
        if (!res.saturated) begin
            mag        = (sval < 0) ? -sval : sval;
            acc_count  = acc_count + 1'b1;
            acc_sum    = acc_sum + sval;
            acc_sum_sq = acc_sum_sq + mag * mag;
        end
        if (acc_count != 0) begin
            n         = 64'(acc_count);
            mean_full = acc_sum / longint'(n);
            asum      = (acc_sum < 0) ? -acc_sum : acc_sum;
            n_sq_sum  = n * acc_sum_sq;
            sum_sq    = asum * asum;
            diff      = (n_sq_sum > sum_sq) ? n_sq_sum - sum_sq : 64'd0;
            var_val   = diff / (n * n);
            res.mean_value = mean_full[rmsd_pkg::FIELD_BITS-1:0];
            res.std_dev    = rmsd_pkg::FIELD_BITS'(floor_sqrt64(var_val));
        end
        res.sample_total = acc_count[rmsd_pkg::FIELD_BITS-1:0];
        // end of run clears after the result
        if (lst) begin
            acc_count  = '0;
            acc_sum    = 0;
            acc_sum_sq = '0;
        end
        return res;
    endfunction

    // Sample mix: rails, small values near zero, full range
    function automatic logic [rmsd_pkg::FIELD_BITS-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return 16'h8000;
        else if (sel < 20)
            return 16'h7FFF;
        else if (sel < 40)
            return rmsd_pkg::FIELD_BITS'($urandom_range(0, 128) - 64);
        else
            return rmsd_pkg::FIELD_BITS'($urandom);
    endfunction

    // Send one request; bursts of random length separated by random gaps
    task automatic push_sample(input logic [rmsd_pkg::FIELD_BITS-1:0] smp,
                               input logic lst);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 180);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_sample <= smp;
        i_last   <= lst;
        do @(posedge i_clk); while (o_stall);
        pending_stats.push_back(predict_stats(smp, lst));
    endtask

    // Hold off the sender until every expected result is out
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    // Single-sample runs at zero, plus and minus one, and both rails
    task automatic test_single_sample_runs();
        push_sample(16'h0000, 1'b1);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h0001, 1'b1);
        push_sample(16'hFFFF, 1'b1);
    endtask

    // Widest spread between the rails, then a constant run at the negative rail
    task automatic test_extreme_spread();
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'h8000, 1'b1);
        repeat (3) push_sample(16'h8000, 1'b0);
        push_sample(16'h8000, 1'b1);
    endtask

    // Negative sums must truncate toward zero
    task automatic test_mean_truncation();
        push_sample(16'hFFFD, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0005, 1'b0);
        push_sample(16'h0000, 1'b1);
    endtask

    // Partial run, full drain, then the run continues
    task automatic test_drain_pause();
        repeat (6) push_sample(pick_sample(), 1'b0);
        drain_results();
        repeat (5) push_sample(pick_sample(), 1'b0);
        push_sample(pick_sample(), 1'b1);
    endtask

    // Runs of random length with random content
    task automatic test_random_runs(input int n_items);
        int run_len;
        int sent;
        sent = 0;
        while (sent < n_items) begin
            run_len = $urandom_range(1, 40);
            for (int k = 0; k < run_len; k++)
                push_sample(pick_sample(), k == run_len - 1);
            sent += run_len;
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end
    endtask

    // One longer run to push the count higher
    task automatic test_long_run();
        for (int k = 0; k < 80; k++)
            push_sample(pick_sample(), k == 79);
    endtask

    // Receiver stall: modes of random length, including solid stalls
    initial begin
        int stall_mode;
        int stall_left;
        stall_mode = 0;
        stall_left = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            case (stall_mode)
                0: begin
                    i_stall <= 1'b0;
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                end
                2: begin
                    i_stall <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_stall <= 1'b1;
                end
            endcase
        end
    end

    // Report one field mismatch
    task automatic compare_field(input string name, input longint exp_val,
                                 input longint act_val);
        if (exp_val != act_val) begin
            $display("%t %s mismatch: expected %0d actual %0d", $realtime, name,
                     exp_val, act_val);
            stats_errors++;
        end
    endtask

    // Result checker
    initial begin
        t_stats_result exp_res;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_stats.size() == 0) begin
                    $display("%t unexpected result: expected none actual mean %0d sd %0d n %0d",
                             $realtime, $signed(o_mean_value), o_std_dev, o_sample_total);
                    stats_errors++;
                end else begin
                    exp_res = pending_stats.pop_front();
                    compare_field("mean_value", exp_res.mean_value, $signed(o_mean_value));
                    compare_field("std_dev", exp_res.std_dev, o_std_dev);
                    compare_field("sample_total", exp_res.sample_total, o_sample_total);
                    compare_field("saturated", exp_res.saturated, o_saturated);
                end
            end
        end
    end

    // Test sequence
    initial begin
        stats_errors = 0;
        burst_left   = 0;
        acc_count    = '0;
        acc_sum      = 0;
        acc_sum_sq   = '0;
        i_rst_n  <= 1'b0;
        i_valid  <= 1'b0;
        i_sample <= '0;
        i_last   <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_sample_runs();
        test_extreme_spread();
        test_mean_truncation();
        test_drain_pause();
        test_random_runs(440);
        test_long_run();

        drain_results();
        repeat (300) @(posedge i_clk);
        if (stats_errors == 0)
            $display("PASS running_mean_std_deviation_top");
        else
            $display("FAIL running_mean_std_deviation_top");
        $finish;
    end

endmodule
